/* rtl/utf8_code_point_decoder_top_assert.svh */
// ----------------------------------------------------------------------------
// UTF-8 code point decoder assertion macros
// Shared assertion wrappers, clocked on clk and disabled during arst_n.
// ----------------------------------------------------------------------------
`ifndef UTF8_CODE_POINT_DECODER_TOP_ASSERT_SVH
`define UTF8_CODE_POINT_DECODER_TOP_ASSERT_SVH

// Hold a property at every clock edge outside reset.
`define U8CPD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check a consequence on the next clock after the trigger.
`define U8CPD_ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/u8cpd_pkg.sv */
// ----------------------------------------------------------------------------
// UTF-8 code point decoder package
// Result status codes, result record, register map and decode constants.
// ----------------------------------------------------------------------------
package u8cpd_pkg;

	typedef enum logic [1:0] {
		ST_CODE = 2'd0,
		ST_END  = 2'd1,
		ST_BAD  = 2'd2
	} status_t;

	localparam int CP_W    = 21;
	localparam int LEN_W   = 3;
	localparam int START_W = 32;
	localparam int ACC_W   = 27;

	localparam logic REG_MULTIBYTE_ENABLE = 1'b0;

	localparam logic [7:0]       LEAD_MULTI = 8'h80;
	localparam logic [7:0]       LEAD_BAD   = 8'hF8;
	localparam logic [ACC_W-1:0] LIMIT_2    = 27'h0003800;
	localparam logic [ACC_W-1:0] LIMIT_3    = 27'h00F0000;
	localparam logic [CP_W-1:0]  MASK_2     = 21'h0007FF;
	localparam logic [CP_W-1:0]  MASK_3     = 21'h00FFFF;
	localparam logic [CP_W-1:0]  MASK_4     = 21'h1FFFFF;

	localparam logic [LEN_W-1:0] LEN_1 = 3'd1;
	localparam logic [LEN_W-1:0] LEN_2 = 3'd2;
	localparam logic [LEN_W-1:0] LEN_3 = 3'd3;
	localparam logic [LEN_W-1:0] LEN_4 = 3'd4;

	typedef struct packed {
		logic [CP_W-1:0]    code_point;
		logic [LEN_W-1:0]   seq_length;
		logic [START_W-1:0] start_offset;
		status_t            status;
		logic               stream_last;
	} result_t;

endpackage

/* rtl/u8cpd_core.sv */
// ----------------------------------------------------------------------------
// UTF-8 code point decoder core
// Sequence state registers and the single-pass byte decode step.
// ----------------------------------------------------------------------------
`include "utf8_code_point_decoder_top_assert.svh"

module u8cpd_core #(
	parameter int OFFSET_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                multibyte_enable,
	input  logic                step,
	input  logic [7:0]          data_byte,
	input  logic                buffer_last,
	output logic                res_valid,
	output u8cpd_pkg::result_t  res
);
	import u8cpd_pkg::*;

	logic [ACC_W-1:0]        acc_q, acc_d, acc_shift;
	logic [LEN_W-1:0]        bt_q, bt_d, bt_inc;
	logic [OFFSET_WIDTH-1:0] off_q, off_d, off_inc;
	logic [OFFSET_WIDTH-1:0] start_q, start_d;
	logic                    halted_q, halted_d;

	assign acc_shift = {acc_q[ACC_W-7:0], data_byte[5:0]};
	assign bt_inc    = bt_q + LEN_1;
	assign off_inc   = off_q + OFFSET_WIDTH'(1);

	always_comb begin
		acc_d               = acc_q;
		bt_d                = bt_q;
		off_d               = off_q;
		start_d             = start_q;
		halted_d            = halted_q;
		res_valid           = 1'b0;
		res.code_point      = '0;
		res.seq_length      = '0;
		res.start_offset    = START_W'(off_q);
		res.status          = ST_CODE;
		res.stream_last     = buffer_last;
		if (halted_q) begin
			// drop
		end else if (bt_q == '0) begin
			if (data_byte == 8'h00) begin
				res_valid  = 1'b1;
				res.status = ST_END;
				halted_d   = 1'b1;
			end else if (data_byte < LEAD_MULTI) begin
				res_valid      = 1'b1;
				res.code_point = CP_W'(data_byte);
				res.seq_length = LEN_1;
				off_d          = off_inc;
			end else if (!multibyte_enable || data_byte >= LEAD_BAD) begin
				res_valid      = 1'b1;
				res.seq_length = LEN_1;
				res.status     = ST_BAD;
				off_d          = off_inc;
				halted_d       = 1'b1;
			end else begin
				start_d = off_q;
				acc_d   = ACC_W'(data_byte);
				bt_d    = LEN_1;
				off_d   = off_inc;
				if (buffer_last) begin
					res_valid      = 1'b1;
					res.seq_length = LEN_1;
					res.status     = ST_BAD;
				end
			end
		end else if (data_byte == 8'h00) begin
			res_valid        = 1'b1;
			res.seq_length   = bt_q;
			res.start_offset = START_W'(start_q);
			res.status       = ST_BAD;
			halted_d         = 1'b1;
			bt_d             = '0;
		end else begin
			acc_d            = acc_shift;
			bt_d             = bt_inc;
			off_d            = off_inc;
			res.start_offset = START_W'(start_q);
			if (bt_inc == LEN_2 && acc_shift < LIMIT_2) begin
				res_valid      = 1'b1;
				res.code_point = acc_shift[CP_W-1:0] & MASK_2;
				res.seq_length = LEN_2;
				bt_d           = '0;
			end else if (bt_inc == LEN_3 && acc_shift < LIMIT_3) begin
				res_valid      = 1'b1;
				res.code_point = acc_shift[CP_W-1:0] & MASK_3;
				res.seq_length = LEN_3;
				bt_d           = '0;
			end else if (bt_inc >= LEN_4) begin
				res_valid      = 1'b1;
				res.code_point = acc_shift[CP_W-1:0] & MASK_4;
				res.seq_length = LEN_4;
				bt_d           = '0;
			end else if (buffer_last) begin
				res_valid      = 1'b1;
				res.seq_length = bt_inc;
				res.status     = ST_BAD;
			end
		end
		if (buffer_last) begin
			acc_d    = '0;
			bt_d     = '0;
			off_d    = '0;
			start_d  = '0;
			halted_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			bt_q     <= '0;
			off_q    <= '0;
			start_q  <= '0;
			halted_q <= 1'b0;
		end else if (step) begin
			acc_q    <= acc_d;
			bt_q     <= bt_d;
			off_q    <= off_d;
			start_q  <= start_d;
			halted_q <= halted_d;
		end
	end

	`U8CPD_ASSERT(a_len_bound, bt_q <= LEN_3, "open sequence longer than three bytes")
	`U8CPD_ASSERT(a_halt_idle, !halted_q || bt_q == '0, "halted with a sequence open")
	`U8CPD_ASSERT_NEXT(a_last_clear, step && buffer_last, off_q == '0 && bt_q == '0 && !halted_q, "state not cleared after buffer end")

endmodule

/* rtl/utf8_code_point_decoder_top.sv */
// ----------------------------------------------------------------------------
// UTF-8 code point decoder top level
// Stream front end, result register and register port around the decode core.
// ----------------------------------------------------------------------------
// One text byte per request is taken at a sustained rate of one byte per
// clock while m_axis_tready does not hold the output; each byte passes an
// input register, and its result then passes the result register.
// Bytes that close no code point, and all bytes after an end or malformed
// report up to the buffer end, give no result. The input side keeps accepting
// while a result waits at the output, as long as the result register is free
// or being emptied. No start-up sweep is needed after reset. Write
// multibyte_enable only while no byte is in flight.

module utf8_code_point_decoder_top #(
	parameter int OFFSET_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,   // [20:0] code_point, [23:21] seq_length,
	                                    // [55:24] start_offset
	output logic [1:0]  m_axis_tuser,   // [1:0] status
	output logic        m_axis_tlast
);
	import u8cpd_pkg::*;

	logic       mb_en_q;
	logic       valid_s1, last_s1;
	logic [7:0] byte_s1;
	logic       valid_s2;
	result_t    res_s2, res;
	logic       res_valid, s2_free, step;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MULTIBYTE_ENABLE) ? {31'd0, mb_en_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mb_en_q <= 1'b1;
		end else if (psel && penable && pwrite && pready &&
		             paddr[2] == REG_MULTIBYTE_ENABLE) begin
			mb_en_q <= pwdata[0];
		end
	end

	assign s2_free       = !valid_s2 || m_axis_tready;
	assign step          = valid_s1 && s2_free;
	assign s_axis_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (s2_free) begin
				valid_s2 <= step && res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
		if (s2_free) begin
			res_s2 <= res;
		end
	end

	u8cpd_core #(
		.OFFSET_WIDTH (OFFSET_WIDTH)
	) u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.multibyte_enable (mb_en_q),
		.step             (step),
		.data_byte        (byte_s1),
		.buffer_last      (last_s1),
		.res_valid        (res_valid),
		.res              (res)
	);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {res_s2.start_offset, res_s2.seq_length, res_s2.code_point};
	assign m_axis_tuser  = res_s2.status;
	assign m_axis_tlast  = res_s2.stream_last;

endmodule
